// ----- hw/rtl/xorshift128_random_source_assert.svh -----
// Assertion macros shared by the checker of the random source.
`ifndef XORSHIFT128_RANDOM_SOURCE_ASSERT_SVH
`define XORSHIFT128_RANDOM_SOURCE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define XRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xrs assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define XRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xrs assertion failed");

`endif

// ----- hw/rtl/xrs_pkg.sv -----
// Package: types, constants and codes of the xorshift128 random source.
package xrs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
  localparam int unsigned MIX_IDX_W = 2;

  localparam logic [WORD_W-1:0] MIX_MUL = 32'd1812433253;
  localparam int unsigned XS_SHL_A  = 11;
  localparam int unsigned XS_SHR_D  = 19;
  localparam int unsigned XS_SHR_T  = 8;
  localparam int unsigned MIX_SHR   = 30;

  typedef enum logic [REQ_W-1:0] {
    REQ_RAW     = 2'd0,
    REQ_BOUNDED = 2'd1,
    REQ_RESEED  = 2'd2,
    REQ_LOAD    = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_VALUE  = 3'd0,
    CFG_LOAD_WORD_A = 3'd1,
    CFG_LOAD_WORD_B = 3'd2,
    CFG_LOAD_WORD_C = 3'd3,
    CFG_LOAD_WORD_D = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_ADVANCE   = 4'd1,
    OP_ZERO_ERR  = 4'd2,
    OP_DIV_START = 4'd3,
    OP_SEED      = 4'd4,
    OP_LOAD      = 4'd5,
    OP_DIV_STEP  = 4'd6,
    OP_MIX_MUL   = 4'd7,
    OP_MIX_ADD   = 4'd8
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_ADD    = 5'b01000,
    ST_FINISH = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic div_last;
    logic mix_last;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] chain_next(logic [WORD_W-1:0] s,
                                                   logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] prod;
    prod = MIX_MUL * (s ^ (s >> MIX_SHR));
    return prod + k;
  endfunction

  localparam logic [WORD_W-1:0] RESET_WORD_A = chain_next(32'd0, 32'd1);
  localparam logic [WORD_W-1:0] RESET_WORD_B = chain_next(RESET_WORD_A, 32'd2);
  localparam logic [WORD_W-1:0] RESET_WORD_C = chain_next(RESET_WORD_B, 32'd3);
  localparam logic [WORD_W-1:0] RESET_WORD_D = chain_next(RESET_WORD_C, 32'd4);

endpackage

// ----- hw/rtl/xrs_if.sv -----
// Request and result channel interfaces of the random source.
interface xrs_req_if import xrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BOUND_W-1:0] upper_bound;

  modport source (output valid, output req_type, output upper_bound, input ready);
  modport sink   (input valid, input req_type, input upper_bound, output ready);
endinterface

interface xrs_rsp_if import xrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              div_error;
  logic [WORD_W-1:0] word_a_out;
  logic [WORD_W-1:0] word_b_out;
  logic [WORD_W-1:0] word_c_out;
  logic [WORD_W-1:0] word_d_out;

  modport source (output valid, output value, output div_error, output word_a_out,
                  output word_b_out, output word_c_out, output word_d_out,
                  input ready);
  modport sink   (input valid, input value, input div_error, input word_a_out,
                  input word_b_out, input word_c_out, input word_d_out,
                  output ready);
endinterface

// ----- hw/rtl/xorshift128_random_source.sv -----
// Top level of the xorshift128 random source: controller and datapath.
// Raw draw, load and zero-bound draw: from ST_IDLE straight to ST_FINISH.
// Bounded draw: restoring divider in ST_DIV, one remainder bit per cycle.
// Reseed: four multiply-then-add steps of the seed mixer, each ST_MUL then ST_ADD.
// One request at a time; a new request is taken while the previous result waits.
// Reset clears config to 0 and loads the seed-zero expansion into the state words.
module xorshift128_random_source import xrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  xrs_req_if.sink              req_i,
  xrs_rsp_if.source            rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  xrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .upper_bound_i (req_i.upper_bound),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_o       (rsp_o.value),
    .div_error_o   (rsp_o.div_error),
    .word_a_o      (rsp_o.word_a_out),
    .word_b_o      (rsp_o.word_b_out),
    .word_c_o      (rsp_o.word_c_out),
    .word_d_o      (rsp_o.word_d_out)
  );

endmodule

// ----- hw/rtl/xrs_ctrl.sv -----
// Controller state machine: sequences draws, divisions, reseeds and the result beat.
module xrs_ctrl import xrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_type_e'(req_type_i))
            REQ_RAW: begin
              cmd_o.op = OP_ADVANCE;
              state_d  = ST_FINISH;
            end
            REQ_BOUNDED: begin
              if (status_i.bound_zero) begin
                cmd_o.op = OP_ZERO_ERR;
                state_d  = ST_FINISH;
              end else begin
                cmd_o.op = OP_DIV_START;
                state_d  = ST_DIV;
              end
            end
            REQ_RESEED: begin
              cmd_o.op = OP_SEED;
              state_d  = ST_MUL;
            end
            default: begin
              cmd_o.op = OP_LOAD;
              state_d  = ST_FINISH;
            end
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MIX_MUL;
        state_d  = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.op = OP_MIX_ADD;
        state_d  = status_i.mix_last ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/xrs_datapath.sv -----
// Datapath: state words, config registers, seed mixer, restoring divider, result register.
module xrs_datapath import xrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  logic [BOUND_W-1:0]   upper_bound_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic [WORD_W-1:0]    value_o,
  output logic                 div_error_o,
  output logic [WORD_W-1:0]    word_a_o,
  output logic [WORD_W-1:0]    word_b_o,
  output logic [WORD_W-1:0]    word_c_o,
  output logic [WORD_W-1:0]    word_d_o
);

  logic [WORD_W-1:0]    seed_q, load_a_q, load_b_q, load_c_q, load_d_q;
  logic [WORD_W-1:0]    word_a_q, word_b_q, word_c_q, word_d_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [MIX_IDX_W-1:0] mix_idx_q;

  logic [WORD_W-1:0]    dividend_q;
  logic [BOUND_W-1:0]   rem_q;
  logic [BOUND_W-1:0]   bound_q;
  logic [WORD_W-1:0]    mul_q;
  logic [WORD_W-1:0]    res_value_q;
  logic                 res_err_q;
  logic [WORD_W-1:0]    out_value_q, out_a_q, out_b_q, out_c_q, out_d_q;
  logic                 out_err_q;

  logic [WORD_W-1:0]    xs_t, xs_next;
  logic [WORD_W-1:0]    rem_shift;
  logic [WORD_W:0]      rem_diff;
  logic [BOUND_W-1:0]   rem_next;
  logic [WORD_W-1:0]    mix_k;

  assign xs_t    = word_a_q ^ (word_a_q << XS_SHL_A);
  assign xs_next = word_d_q ^ (word_d_q >> XS_SHR_D) ^ xs_t ^ (xs_t >> XS_SHR_T);

  assign rem_shift = {rem_q, dividend_q[WORD_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, bound_q};
  assign rem_next  = rem_diff[WORD_W] ? rem_shift[BOUND_W-1:0] : rem_diff[BOUND_W-1:0];

  assign mix_k = {{(WORD_W-MIX_IDX_W){1'b0}}, mix_idx_q} + {{(WORD_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      load_a_q  <= '0;
      load_b_q  <= '0;
      load_c_q  <= '0;
      load_d_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SEED_VALUE:  seed_q   <= cfg_data_i;
        CFG_LOAD_WORD_A: load_a_q <= cfg_data_i;
        CFG_LOAD_WORD_B: load_b_q <= cfg_data_i;
        CFG_LOAD_WORD_C: load_c_q <= cfg_data_i;
        CFG_LOAD_WORD_D: load_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q  <= RESET_WORD_A;
      word_b_q  <= RESET_WORD_B;
      word_c_q  <= RESET_WORD_C;
      word_d_q  <= RESET_WORD_D;
      div_cnt_q <= '0;
      mix_idx_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_ADVANCE, OP_DIV_START: begin
          word_a_q  <= word_b_q;
          word_b_q  <= word_c_q;
          word_c_q  <= word_d_q;
          word_d_q  <= xs_next;
          div_cnt_q <= '0;
        end
        OP_SEED: begin
          word_d_q  <= seed_q;
          mix_idx_q <= '0;
        end
        OP_LOAD: begin
          word_a_q <= load_a_q;
          word_b_q <= load_b_q;
          word_c_q <= load_c_q;
          word_d_q <= load_d_q;
        end
        OP_DIV_STEP: begin
          div_cnt_q <= div_cnt_q + 1'b1;
        end
        OP_MIX_ADD: begin
          word_a_q  <= word_b_q;
          word_b_q  <= word_c_q;
          word_c_q  <= word_d_q;
          word_d_q  <= mul_q + mix_k;
          mix_idx_q <= mix_idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ADVANCE: begin
        res_value_q <= xs_next;
        res_err_q   <= 1'b0;
      end
      OP_ZERO_ERR: begin
        res_value_q <= '0;
        res_err_q   <= 1'b1;
      end
      OP_DIV_START: begin
        dividend_q  <= xs_next;
        rem_q       <= '0;
        bound_q     <= upper_bound_i;
        res_err_q   <= 1'b0;
      end
      OP_DIV_STEP: begin
        dividend_q  <= dividend_q << 1;
        rem_q       <= rem_next;
        res_value_q <= {1'b0, rem_next};
      end
      OP_SEED, OP_LOAD: begin
        res_value_q <= '0;
        res_err_q   <= 1'b0;
      end
      OP_MIX_MUL: begin
        mul_q <= MIX_MUL * (word_d_q ^ (word_d_q >> MIX_SHR));
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_value_q <= res_value_q;
      out_err_q   <= res_err_q;
      out_a_q     <= word_a_q;
      out_b_q     <= word_b_q;
      out_c_q     <= word_c_q;
      out_d_q     <= word_d_q;
    end
  end

  assign status_o.bound_zero = (upper_bound_i == '0);
  assign status_o.div_last   = (div_cnt_q == DIV_CNT_W'(WORD_W - 1));
  assign status_o.mix_last   = (mix_idx_q == '1);

  assign value_o     = out_value_q;
  assign div_error_o = out_err_q;
  assign word_a_o    = out_a_q;
  assign word_b_o    = out_b_q;
  assign word_c_o    = out_c_q;
  assign word_d_o    = out_d_q;

endmodule

// ----- hw/rtl/xorshift128_random_source_checker.sv -----
// Port-level checker of the random source and its bind to the top level.
`include "xorshift128_random_source_assert.svh"

module xorshift128_random_source_checker import xrs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [WORD_W-1:0] rsp_value_i,
  input logic              rsp_div_error_i
);

  `XRS_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `XRS_ASSERT_NEXT(a_rsp_value_hold, rsp_valid_i && !rsp_ready_i, $stable(rsp_value_i))
  `XRS_ASSERT_NOW(a_err_zero_value, rsp_valid_i && rsp_div_error_i, rsp_value_i == '0)
  `XRS_ASSERT_NEXT(a_one_req_at_a_time, req_valid_i && req_ready_i, !req_ready_i)

endmodule

bind xorshift128_random_source xorshift128_random_source_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_value_i     (rsp_o.value),
  .rsp_div_error_i (rsp_o.div_error)
);

// ----- tb/testbench.sv -----
// Self-checking testbench of the xorshift128 random source: directed, random and stalled traffic.
module testbench import xrs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CHUNK_ITEMS  = 45;
  localparam int unsigned CHUNKS       = 3;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              div_error;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;
  } draw_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  xrs_req_if req_bus ();
  xrs_rsp_if rsp_bus ();

  xorshift128_random_source DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  logic [WORD_W-1:0] gen_word [4];
  logic [WORD_W-1:0] load_reg [4];
  logic [WORD_W-1:0] seed_reg;
  draw_result_t      expected_draws [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned receiver_hold  = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned checked_count  = 0;
  int unsigned zero_bound_count = 0;
  int unsigned kind_count [4] = '{0, 0, 0, 0};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (receiver_hold > 0) begin
      rsp_bus.ready <= 1'b0;
      receiver_hold--;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    $display("testbench: MISMATCH %s got %08h expected %08h (cycle %0d)",
             field, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected result beat, value", rsp_bus.value, '0);
      end else begin
        want = expected_draws.pop_front();
        checked_count++;
        if (rsp_bus.value !== want.value)
          report_mismatch("value", rsp_bus.value, want.value);
        if (rsp_bus.div_error !== want.div_error)
          report_mismatch("div_error", WORD_W'(rsp_bus.div_error), WORD_W'(want.div_error));
        if (rsp_bus.word_a_out !== want.word_a)
          report_mismatch("word_a_out", rsp_bus.word_a_out, want.word_a);
        if (rsp_bus.word_b_out !== want.word_b)
          report_mismatch("word_b_out", rsp_bus.word_b_out, want.word_b);
        if (rsp_bus.word_c_out !== want.word_c)
          report_mismatch("word_c_out", rsp_bus.word_c_out, want.word_c);
        if (rsp_bus.word_d_out !== want.word_d)
          report_mismatch("word_d_out", rsp_bus.word_d_out, want.word_d);
      end
    end
  end

  function automatic void expand_seed_words(logic [WORD_W-1:0] s);
    for (int k = 0; k < 4; k++) begin
      s = MIX_MUL * (s ^ (s >> MIX_SHR)) + (k + 1);
      gen_word[k] = s;
    end
  endfunction

  function automatic logic [WORD_W-1:0] xorshift_step();
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] nd;
    t  = gen_word[0] ^ (gen_word[0] << XS_SHL_A);
    nd = gen_word[3] ^ (gen_word[3] >> XS_SHR_D) ^ t ^ (t >> XS_SHR_T);
    gen_word[0] = gen_word[1];
    gen_word[1] = gen_word[2];
    gen_word[2] = gen_word[3];
    gen_word[3] = nd;
    return nd;
  endfunction

  function automatic void predict_draw(req_type_e kind, logic [BOUND_W-1:0] bound);
    draw_result_t want;
    want = '0;
    kind_count[kind]++;
    case (kind)
      REQ_RAW: want.value = xorshift_step();
      REQ_BOUNDED: begin
        if (bound == '0) begin
          want.div_error = 1'b1;
          zero_bound_count++;
        end else begin
          want.value = xorshift_step() % {1'b0, bound};
        end
      end
      REQ_RESEED: expand_seed_words(seed_reg);
      default: begin
        for (int k = 0; k < 4; k++) gen_word[k] = load_reg[k];
      end
    endcase
    want.word_a = gen_word[0];
    want.word_b = gen_word[1];
    want.word_c = gen_word[2];
    want.word_d = gen_word[3];
    expected_draws.push_back(want);
  endfunction

  task automatic send_request(req_type_e kind, logic [BOUND_W-1:0] bound);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.upper_bound <= bound;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    predict_draw(kind, bound);
  endtask

  task automatic hold_requests();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    hold_requests();
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SEED_VALUE:  seed_reg    = data;
      CFG_LOAD_WORD_A: load_reg[0] = data;
      CFG_LOAD_WORD_B: load_reg[1] = data;
      CFG_LOAD_WORD_C: load_reg[2] = data;
      CFG_LOAD_WORD_D: load_reg[3] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_load_words(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                  logic [WORD_W-1:0] c, logic [WORD_W-1:0] d);
    write_register(CFG_LOAD_WORD_A, a);
    write_register(CFG_LOAD_WORD_B, b);
    write_register(CFG_LOAD_WORD_C, c);
    write_register(CFG_LOAD_WORD_D, d);
  endtask

  function automatic logic [BOUND_W-1:0] random_bound();
    case ($urandom_range(9))
      0:       return '0;
      1:       return BOUND_W'(1);
      2:       return '1;
      3, 4:    return BOUND_W'($urandom_range(16, 1));
      5, 6:    return BOUND_W'($urandom_range(65535, 1));
      default: return BOUND_W'($urandom());
    endcase
  endfunction

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)
      send_request(REQ_RAW, BOUND_W'($urandom()));
    else if (pick < 80)
      send_request(REQ_BOUNDED, random_bound());
    else if (pick < 90)
      send_request(REQ_RESEED, BOUND_W'($urandom()));
    else
      send_request(REQ_LOAD, BOUND_W'($urandom()));
  endtask

  task automatic test_reset_state();
    send_request(REQ_RAW, '0);
    send_request(REQ_RAW, '1);
    send_request(REQ_BOUNDED, BOUND_W'(1));
    send_request(REQ_BOUNDED, '1);
    send_request(REQ_BOUNDED, '0);
    send_request(REQ_BOUNDED, BOUND_W'(31'h5555_5555));
    send_request(REQ_BOUNDED, BOUND_W'(31'h2AAA_AAAA));
    send_request(REQ_RESEED, '0);
    send_request(REQ_LOAD, '0);
    send_request(REQ_RAW, '0);
    send_request(REQ_BOUNDED, BOUND_W'(7));
    send_request(REQ_RESEED, '1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_register(CFG_SEED_VALUE, '1);
    write_load_words('1, '1, '1, '1);
    send_request(REQ_RESEED, '0);
    send_request(REQ_RAW, '0);
    send_request(REQ_LOAD, '0);
    send_request(REQ_BOUNDED, '1);
    wait_drained();
    for (int i = CFG_LOAD_WORD_D + 1; i < 2 ** CFG_IDX_W; i++)
      write_register(i[CFG_IDX_W-1:0], $urandom());
    send_request(REQ_RESEED, '0);
    send_request(REQ_LOAD, '0);
    wait_drained();
    write_register(CFG_SEED_VALUE, '0);
    write_load_words(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0000);
    send_request(REQ_LOAD, '0);
    send_request(REQ_RAW, '0);
    send_request(REQ_BOUNDED, BOUND_W'(3));
    send_request(REQ_RESEED, '0);
    wait_drained();
    write_load_words('0, '0, '0, '0);
    send_request(REQ_LOAD, '0);
    send_request(REQ_RAW, '0);
    send_request(REQ_RESEED, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int c = 0; c < CHUNKS; c++) begin
      write_register(CFG_SEED_VALUE, $urandom());
      write_load_words($urandom(), $urandom(), $urandom(), $urandom());
      repeat (CHUNK_ITEMS) send_random_request();
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    receiver_hold = HOLD_CYCLES;
    repeat (24) send_random_request();
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_RAW;
    req_bus.upper_bound = '0;
    rsp_bus.ready       = 1'b0;
    seed_reg            = '0;
    for (int k = 0; k < 4; k++) load_reg[k] = '0;
    expand_seed_words('0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(45, 0);
    test_random_traffic(0, 45);
    test_random_traffic(29, 29);
    test_output_backpressure();

    hold_requests();
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("testbench: %0d results checked: raw %0d, bounded %0d (%0d with zero bound), reseed %0d, load %0d",
             checked_count, kind_count[REQ_RAW], kind_count[REQ_BOUNDED], zero_bound_count,
             kind_count[REQ_RESEED], kind_count[REQ_LOAD]);
    $display("testbench: idle mixes none/sender/receiver/both, %0d-cycle output hold, %0d mismatches",
             HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
